### src/mcms_pkg.sv
// ----------------------------------------------------------------------------
// mcms_pkg
// shared types and constants of the masked column mean / deviation unit
// ----------------------------------------------------------------------------
package mcms_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int QUALITY_BITS = 16;
  localparam int COUNT_OUT_W  = 13;
  localparam int COLUMN_MAX_D = 4096;
  localparam int FRAC_BITS    = 8;

  typedef enum logic {
    REG_QUALITY_MASK   = 1'b0,
    REG_QUALITY_ENABLE = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]     sample;
    logic                           sample_bad;
    logic        [QUALITY_BITS-1:0] quality_word;
    logic                           last_in_column;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0]            mean_value;
    logic        [31:0]            std_dev;
    logic        [COUNT_OUT_W-1:0] good_count;
    logic                          result_valid;
    logic                          overflow;
  } out_word_t;

endpackage

### src/mcms_queue.sv
// ----------------------------------------------------------------------------
// mcms_queue
// two-entry queue of finished column sums between front and back
// ----------------------------------------------------------------------------
module mcms_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

### src/mcms_front.sv
// ----------------------------------------------------------------------------
// mcms_front
// sample screening and running sums, one sample a cycle while take is high
// ----------------------------------------------------------------------------
module mcms_front
  import mcms_pkg::*;
#(
  parameter int COLUMN_MAX = COLUMN_MAX_D,
  parameter int CNT_W      = 13,
  parameter int S1_W       = 37,
  parameter int S2_W       = 59
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  in_word_t                      item,
  input  logic [QUALITY_BITS-1:0]       quality_mask,
  input  logic                          quality_enable,
  output logic                          rec_wr,
  output logic [1+CNT_W+S2_W+S1_W-1:0]  rec
);

  logic signed [S1_W-1:0]     running_sum, running_sum_next;
  logic        [S2_W-1:0]     running_square_sum, running_square_sum_next;
  logic        [CNT_W-1:0]    sample_count, sample_count_next;
  logic                       overflow_seen, overflow_seen_next;
  logic                       good;
  logic        [SAMPLE_W-1:0] mag;
  logic        [2*SAMPLE_W-1:0] sq;

  always_comb begin
    good = !item.sample_bad &&
           !(quality_enable && ((item.quality_word & quality_mask) != '0));
    mag  = item.sample[SAMPLE_W-1] ? SAMPLE_W'(-item.sample) : item.sample;
    sq   = mag * mag;
    running_sum_next        = running_sum;
    running_square_sum_next = running_square_sum;
    sample_count_next       = sample_count;
    overflow_seen_next      = overflow_seen;
    if (good) begin
      if (sample_count >= CNT_W'(COLUMN_MAX)) begin
        overflow_seen_next = 1'b1;
      end else begin
        running_sum_next        = running_sum + S1_W'(item.sample);
        running_square_sum_next = running_square_sum + S2_W'(sq);
        sample_count_next       = sample_count + 1'b1;
      end
    end
  end

  assign rec_wr = take && item.last_in_column;
  assign rec    = {overflow_seen_next, sample_count_next,
                   running_square_sum_next, running_sum_next};

  always_ff @(posedge clk) begin
    if (rst || rec_wr) begin
      running_sum        <= '0;
      running_square_sum <= '0;
      sample_count       <= '0;
      overflow_seen      <= 1'b0;
    end else if (take) begin
      running_sum        <= running_sum_next;
      running_square_sum <= running_square_sum_next;
      sample_count       <= sample_count_next;
      overflow_seen      <= overflow_seen_next;
    end
  end

endmodule

### src/mcms_back.sv
// ----------------------------------------------------------------------------
// mcms_back
// per-column sequencer: shift-add multiply, restoring divide, bitwise root
// ----------------------------------------------------------------------------
module mcms_back
  import mcms_pkg::*;
#(
  parameter int CNT_W = 13,
  parameter int S1_W  = 37,
  parameter int S2_W  = 59
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rec_empty,
  input  logic [1+CNT_W+S2_W+S1_W-1:0]  rec,
  output logic                          rec_rd,
  input  logic                          pop,
  output logic                          empty,
  output out_word_t                     result
);

  localparam int PW     = 2 * S1_W;
  localparam int QW     = PW + 2 * FRAC_BITS;
  localparam int DS_W   = 2 * CNT_W;
  localparam int RW     = QW / 2;
  localparam int STEP_W = $clog2(QW + 1);

  typedef enum logic [2:0] {
    IDLE, DIVM, MULA, MULB, SUB, DIVQ, SQRT, DONE
  } state_t;

  state_t                 state;
  logic [S2_W-1:0]        s2;
  logic [CNT_W-1:0]       n;
  logic                   ovf;
  logic                   neg;
  logic [S1_W-1:0]        mag;
  logic [PW-1:0]          acc, ma, prod;
  logic [S1_W-1:0]        mb;
  logic [QW-1:0]          dq;
  logic [DS_W-1:0]        rem, dvs;
  logic [RW-1:0]          root;
  logic [RW+1:0]          srem;
  logic [STEP_W-1:0]      cnt;
  logic [31:0]            mean_r;
  logic [31:0]            sd_r;

  logic signed [S1_W-1:0] rec_s1;
  logic [DS_W:0]          div_sh, div_tr;
  logic [RW+3:0]          sq_sh, sq_tr;
  logic [PW-1:0]          diff;
  logic                   last_step;
  logic [31:0]            quo_last;

  always_comb begin
    rec_s1    = rec[S1_W-1:0];
    div_sh    = {rem, dq[QW-1]};
    div_tr    = div_sh - {1'b0, dvs};
    sq_sh     = {srem, dq[QW-1:QW-2]};
    sq_tr     = {2'b00, root, 2'b01};
    diff      = (prod >= acc) ? prod - acc : '0;
    last_step = (cnt == STEP_W'(1));
    // quotient including the bit settled this cycle
    quo_last  = {dq[30:0], !div_tr[DS_W]};
  end

  assign rec_rd = (state == IDLE) && !rec_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      empty <= 1'b1;
    end else begin
      if ((state == DONE) && (empty || pop)) empty <= 1'b0;
      else if (pop && !empty) empty <= 1'b1;
      case (state)
        IDLE: begin
          if (!rec_empty) begin
            s2     <= rec[S1_W +: S2_W];
            n      <= rec[S1_W+S2_W +: CNT_W];
            ovf    <= rec[S1_W+S2_W+CNT_W];
            neg    <= rec_s1[S1_W-1];
            mag    <= rec_s1[S1_W-1] ? S1_W'(-rec_s1) : rec_s1;
            mean_r <= '0;
            sd_r   <= '0;
            state  <= (rec[S1_W+S2_W +: CNT_W] == '0) ? DONE : DIVM;
            dq     <= QW'(rec_s1[S1_W-1] ? S1_W'(-rec_s1) : rec_s1) << FRAC_BITS;
            dvs    <= DS_W'(rec[S1_W+S2_W +: CNT_W]);
            rem    <= '0;
            cnt    <= STEP_W'(QW);
          end
        end
        DIVM, DIVQ: begin
          // one quotient bit a cycle
          if (!div_tr[DS_W]) begin
            rem <= div_tr[DS_W-1:0];
            dq  <= {dq[QW-2:0], 1'b1};
          end else begin
            rem <= div_sh[DS_W-1:0];
            dq  <= {dq[QW-2:0], 1'b0};
          end
          if (!last_step) begin
            cnt <= cnt - 1'b1;
          end else if (state == DIVM) begin
            mean_r <= neg ? 32'(-quo_last) : quo_last;
            acc    <= '0;
            ma     <= PW'(s2);
            mb     <= S1_W'(n);
            cnt    <= STEP_W'(CNT_W);
            state  <= (n == CNT_W'(1)) ? DONE : MULA;
          end else begin
            srem  <= '0;
            root  <= '0;
            cnt   <= STEP_W'(RW);
            state <= SQRT;
          end
        end
        MULA, MULB: begin
          if (!last_step) begin
            if (mb[0]) acc <= acc + ma;
            ma  <= ma << 1;
            mb  <= mb >> 1;
            cnt <= cnt - 1'b1;
          end else if (state == MULA) begin
            prod  <= mb[0] ? acc + ma : acc;
            acc   <= '0;
            ma    <= PW'(mag);
            mb    <= mag;
            cnt   <= STEP_W'(S1_W);
            state <= MULB;
          end else begin
            if (mb[0]) acc <= acc + ma;
            state <= SUB;
          end
        end
        SUB: begin
          dq    <= {diff, {(2*FRAC_BITS){1'b0}}};
          dvs   <= DS_W'(n) * DS_W'(n - 1'b1);
          rem   <= '0;
          cnt   <= STEP_W'(QW);
          state <= DIVQ;
        end
        SQRT: begin
          // two radicand bits a cycle
          if (sq_sh >= sq_tr) begin
            srem <= RW'(0) + (RW+2)'(sq_sh - sq_tr);
            root <= {root[RW-2:0], 1'b1};
          end else begin
            srem <= (RW+2)'(sq_sh);
            root <= {root[RW-2:0], 1'b0};
          end
          dq <= dq << 2;
          if (last_step) state <= DONE;
          else cnt <= cnt - 1'b1;
        end
        DONE: begin
          if (empty || pop) begin
            result.mean_value   <= mean_r;
            result.std_dev      <= (n > CNT_W'(1)) ?
                                   ((|root[RW-1:32]) ? 32'hFFFF_FFFF : root[31:0]) : sd_r;
            result.good_count   <= COUNT_OUT_W'(n);
            result.result_valid <= (n != '0);
            result.overflow     <= ovf;
            state               <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### src/masked_column_mean_stddev_unit.sv
// ----------------------------------------------------------------------------
// masked_column_mean_stddev_unit
// masked per-column mean and sample standard deviation, 8 fractional bits
// ----------------------------------------------------------------------------
//  channel   direction  handshake            word
//  item      in         push / full          in_word_t (one sample)
//  result    out        pop / empty          out_word_t (one per column)
//  config    in         cfg_we, no wait      cfg_index, cfg_data
//
//  samples go in at one a cycle while full is low; the front adds them
//  to exact running sums; a column's sums pass a two-entry queue to a
//  sequencer that divides for the mean, multiplies, subtracts, divides
//  again and takes a root; full rises while both queue entries wait
//  a finished word sits in the result register until popped
//  reset is synchronous and clears sums, the queue and the config registers
// ----------------------------------------------------------------------------
module masked_column_mean_stddev_unit
  import mcms_pkg::*;
#(
  parameter int COLUMN_MAX = COLUMN_MAX_D
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_word_t    item,
  input  logic        pop,
  output logic        empty,
  output out_word_t   result,
  input  logic        cfg_we,
  input  reg_index_t  cfg_index,
  input  logic [15:0] cfg_data
);

  // count must hold the limit itself
  localparam int CNT_W = $clog2(COLUMN_MAX + 1);
  localparam int S1_W  = SAMPLE_W + CNT_W;
  localparam int S2_W  = 2 * SAMPLE_W - 2 + CNT_W;
  localparam int REC_W = 1 + CNT_W + S2_W + S1_W;

  logic [QUALITY_BITS-1:0] quality_mask;
  logic                    quality_enable;
  logic                    take;
  logic                    rec_wr, rec_rd, rec_empty;
  logic [REC_W-1:0]        rec_in, rec_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quality_mask   <= '0;
      quality_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUALITY_MASK:   quality_mask   <= cfg_data;
        REG_QUALITY_ENABLE: quality_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign take = push && !full;

  mcms_front #(
    .COLUMN_MAX (COLUMN_MAX),
    .CNT_W      (CNT_W),
    .S1_W       (S1_W),
    .S2_W       (S2_W)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .item           (item),
    .quality_mask   (quality_mask),
    .quality_enable (quality_enable),
    .rec_wr         (rec_wr),
    .rec            (rec_in)
  );

  // column sums waiting for the sequencer
  mcms_queue #(
    .W (REC_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (rec_wr),
    .wdata (rec_in),
    .rd    (rec_rd),
    .rdata (rec_out),
    .full  (full),
    .empty (rec_empty)
  );

  mcms_back #(
    .CNT_W (CNT_W),
    .S1_W  (S1_W),
    .S2_W  (S2_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_empty (rec_empty),
    .rec       (rec_out),
    .rec_rd    (rec_rd),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule
